FILE: rtl/urbc_pkg.sv
// Shared constants and types for the rule bitmap classifier.
package urbc_pkg;

    localparam int RULE_COUNT    = 64;
    localparam int TABLE_ENTRIES = 256;
    localparam int CLASS_COUNT   = 3;

    localparam int BM_W       = 64;
    localparam int GROUP_SIZE = (TABLE_ENTRIES >= 16) ? 16 : 4;
    localparam int NUM_GROUPS = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GSEL_W     = $clog2(GROUP_SIZE);
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int IDX_W      = GRP_W + GSEL_W;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_FIND   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic CFG_WILDCARD_UID = 1'b0;
    localparam logic CFG_LEARN_MODE   = 1'b1;

    // write command broadcast along the cell row
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic             valid;
        logic [1:0]       cls;
        logic [31:0]      user;
        logic [BM_W-1:0]  bitmap;
    } t_cell_wr;

    // per-group reduction result
    typedef struct packed {
        logic              any_hit;
        logic [GSEL_W-1:0] hit_idx;
        logic [BM_W-1:0]   hit_bm;
        logic              any_free;
        logic [GSEL_W-1:0] free_idx;
    } t_grp_res;

endpackage

FILE: rtl/urbc_cell.sv
// One table entry: stored key and bitmap, registered match and free flags.
module urbc_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [urbc_pkg::IDX_W-1:0] i_own_idx,
    input  logic [1:0]               i_key_cls,
    input  logic [31:0]              i_key_user,
    input  urbc_pkg::t_cell_wr       i_wr,
    output logic                     o_hit,
    output logic                     o_free,
    output logic [urbc_pkg::BM_W-1:0] o_bitmap
);

    logic                      r_valid;
    logic [1:0]                r_cls;
    logic [31:0]               r_user;
    logic [urbc_pkg::BM_W-1:0] r_bitmap;
    logic                      r_hit;
    logic                      r_free;
    logic                      n_hit;

    assign n_hit = r_valid && (r_cls == i_key_cls) && (r_user == i_key_user);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            r_hit  <= n_hit;
            r_free <= !r_valid;
            if (i_wr.we && (i_wr.idx == i_own_idx)) begin
                r_valid <= i_wr.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we && (i_wr.idx == i_own_idx)) begin
            r_cls    <= i_wr.cls;
            r_user   <= i_wr.user;
            r_bitmap <= i_wr.bitmap;
        end
    end

    assign o_hit    = r_hit;
    assign o_free   = r_free;
    assign o_bitmap = r_bitmap;

endmodule

FILE: rtl/urbc_group.sv
// Registered reduction over one group of cells: match select and lowest free slot.
module urbc_group (
    input  logic                      i_clk,
    input  logic [urbc_pkg::GROUP_SIZE-1:0] i_hit,
    input  logic [urbc_pkg::GROUP_SIZE-1:0] i_free,
    input  logic [urbc_pkg::BM_W-1:0] i_bitmap [urbc_pkg::GROUP_SIZE],
    output urbc_pkg::t_grp_res        o_res
);

    urbc_pkg::t_grp_res r_res;
    urbc_pkg::t_grp_res n_res;

    always_comb begin
        n_res          = '0;
        n_res.any_hit  = |i_hit;
        n_res.any_free = |i_free;
        // at most one cell matches, so an OR of the masked values selects it
        for (int j = 0; j < urbc_pkg::GROUP_SIZE; j++) begin
            if (i_hit[j]) begin
                n_res.hit_bm  = n_res.hit_bm | i_bitmap[j];
                n_res.hit_idx = n_res.hit_idx | urbc_pkg::GSEL_W'(j);
            end
        end
        for (int j = urbc_pkg::GROUP_SIZE - 1; j >= 0; j--) begin
            if (i_free[j]) begin
                n_res.free_idx = urbc_pkg::GSEL_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

FILE: rtl/uid_rule_bitmap_classifier_top.sv
// Top level: command sequencer, wildcard bitmaps and the row of table cells.
// Sequence: the command is registered on accept, then the cells compare, two
// registered reduction levels follow, and the execute state drives the result.
// Busy is high from accept until the result is driven (compare, two registered
// reduction levels, execute); a new command is taken only back in idle.
// Reset: synchronous active low; clears all entries and wildcard bitmaps and
// restores the config registers to their defaults. The receiver cannot stall.
module uid_rule_bitmap_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_rule_type,
    input  logic [6:0]  i_rule_index,
    input  logic [31:0] i_user_id,
    input  logic [63:0] i_verdict_in,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [63:0] o_verdict_out,
    output logic [6:0]  o_free_rule
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_RED1 = 3'd2;
    localparam logic [2:0] S_RED2 = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;

    localparam int BM_W = urbc_pkg::BM_W;
    localparam int GS   = urbc_pkg::GROUP_SIZE;
    localparam int NG   = urbc_pkg::NUM_GROUPS;
    localparam int IW   = urbc_pkg::IDX_W;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [31:0] r_wuid;
    logic        r_learn;
    logic [BM_W-1:0] r_wild [urbc_pkg::CLASS_COUNT];

    logic [1:0]  r_mode;
    logic [1:0]  r_cls;
    logic [6:0]  r_rule;
    logic [31:0] r_user;
    logic [63:0] r_verdict;

    logic            r_hit;
    logic [IW-1:0]   r_hit_idx;
    logic [BM_W-1:0] r_hit_bm;
    logic            r_any_free;
    logic [IW-1:0]   r_free_idx;

    logic            n_hit;
    logic [IW-1:0]   n_hit_idx;
    logic [BM_W-1:0] n_hit_bm;
    logic            n_any_free;
    logic [IW-1:0]   n_free_idx;

    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic [63:0] r_o_verdict;
    logic [6:0]  r_o_free;

    urbc_pkg::t_cell_wr s_wr;
    logic [1:0]         s_status;
    logic [63:0]        s_vout;
    logic [6:0]         s_free;
    logic               s_wild_we;
    logic [BM_W-1:0]    s_wild_new;
    logic [BM_W-1:0]    s_bit;
    logic [BM_W-1:0]    s_wild;
    logic [BM_W-1:0]    s_clear;
    logic [BM_W-1:0]    s_rule_mask;

    logic [NG*GS-1:0]   s_hit;
    logic [NG*GS-1:0]   s_freev;
    logic [BM_W-1:0]    s_bm [NG*GS];
    urbc_pkg::t_grp_res s_grp [NG];

    // row of cells, padded to whole groups
    for (genvar g = 0; g < NG * GS; g++) begin : g_cell
        if (g < urbc_pkg::TABLE_ENTRIES) begin : g_real
            urbc_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_own_idx  (IW'(g)),
                .i_key_cls  (r_cls),
                .i_key_user (r_user),
                .i_wr       (s_wr),
                .o_hit      (s_hit[g]),
                .o_free     (s_freev[g]),
                .o_bitmap   (s_bm[g])
            );
        end else begin : g_pad
            assign s_hit[g]   = 1'b0;
            assign s_freev[g] = 1'b0;
            assign s_bm[g]    = '0;
        end
    end

    for (genvar k = 0; k < NG; k++) begin : g_grp
        urbc_group u_group (
            .i_clk    (i_clk),
            .i_hit    (s_hit[k*GS +: GS]),
            .i_free   (s_freev[k*GS +: GS]),
            .i_bitmap (s_bm[k*GS +: GS]),
            .o_res    (s_grp[k])
        );
    end

    // second reduction level across groups
    always_comb begin
        n_hit      = 1'b0;
        n_hit_idx  = '0;
        n_hit_bm   = '0;
        n_any_free = 1'b0;
        n_free_idx = '0;
        for (int k = 0; k < NG; k++) begin
            if (s_grp[k].any_hit) begin
                n_hit     = 1'b1;
                n_hit_bm  = n_hit_bm | s_grp[k].hit_bm;
                n_hit_idx = n_hit_idx |
                            {urbc_pkg::GRP_W'(k), s_grp[k].hit_idx};
            end
        end
        for (int k = NG - 1; k >= 0; k--) begin
            if (s_grp[k].any_free) begin
                n_any_free = 1'b1;
                n_free_idx = {urbc_pkg::GRP_W'(k), s_grp[k].free_idx};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_CMP;
            S_CMP:   n_state = S_RED1;
            S_RED1:  n_state = S_RED2;
            S_RED2:  n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_rule_mask = (urbc_pkg::RULE_COUNT >= 64) ? '1 :
                      ((BM_W'(1) << urbc_pkg::RULE_COUNT) - BM_W'(1));
        s_bit      = BM_W'(1) << r_rule[5:0];
        s_wild     = (r_cls < 2'(urbc_pkg::CLASS_COUNT)) ? r_wild[r_cls] : '0;
        s_clear    = ~r_hit_bm & s_rule_mask;
        s_free     = 7'(urbc_pkg::RULE_COUNT);
        for (int b = urbc_pkg::RULE_COUNT - 1; b >= 0; b--) begin
            if (s_clear[b]) s_free = 7'(b);
        end
        s_wr       = '0;
        s_wr.cls   = r_cls;
        s_wr.user  = r_user;
        s_status   = urbc_pkg::ST_OK;
        s_vout     = '0;
        s_wild_we  = 1'b0;
        s_wild_new = s_wild;
        if (r_cls >= 2'(urbc_pkg::CLASS_COUNT)) begin
            s_status = urbc_pkg::ST_INVALID;
            s_free   = '0;
        end else begin
            case (r_mode)
                urbc_pkg::MODE_ADD, urbc_pkg::MODE_DELETE: begin
                    s_free = '0;
                    if (r_rule >= 7'(urbc_pkg::RULE_COUNT)) begin
                        s_status = urbc_pkg::ST_INVALID;
                    end else if (r_user == r_wuid) begin
                        if (r_mode == urbc_pkg::MODE_ADD) begin
                            s_wild_we  = 1'b1;
                            s_wild_new = s_wild | s_bit;
                        end else if ((s_wild & s_bit) == '0) begin
                            s_status = urbc_pkg::ST_ABSENT;
                        end else begin
                            s_wild_we  = 1'b1;
                            s_wild_new = s_wild & ~s_bit;
                        end
                    end else if (r_mode == urbc_pkg::MODE_ADD) begin
                        if (r_hit) begin
                            s_wr.we     = 1'b1;
                            s_wr.idx    = r_hit_idx;
                            s_wr.valid  = 1'b1;
                            s_wr.bitmap = r_hit_bm | s_bit;
                        end else if (r_any_free) begin
                            s_wr.we     = 1'b1;
                            s_wr.idx    = r_free_idx;
                            s_wr.valid  = 1'b1;
                            s_wr.bitmap = s_bit;
                        end else begin
                            s_status = urbc_pkg::ST_FULL;
                        end
                    end else begin
                        if (!r_hit || ((r_hit_bm & s_bit) == '0)) begin
                            s_status = urbc_pkg::ST_ABSENT;
                        end else begin
                            s_wr.we     = 1'b1;
                            s_wr.idx    = r_hit_idx;
                            s_wr.bitmap = r_hit_bm & ~s_bit;
                            s_wr.valid  = |(r_hit_bm & ~s_bit);
                        end
                    end
                end
                urbc_pkg::MODE_SEARCH: begin
                    s_free = '0;
                    if (r_hit) s_vout = r_verdict & (r_hit_bm | s_wild);
                    else if (!r_learn) s_vout = r_verdict & s_wild;
                end
                default: begin
                    if (!r_hit) begin
                        s_status = urbc_pkg::ST_ABSENT;
                        s_free   = '0;
                    end
                end
            endcase
        end
        // apply only in the execute cycle
        if (r_state != S_EXEC) begin
            s_wr.we   = 1'b0;
            s_wild_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wuid    <= '1;
            r_learn   <= 1'b0;
            r_o_valid <= 1'b0;
            for (int c = 0; c < urbc_pkg::CLASS_COUNT; c++) r_wild[c] <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= (r_state == S_EXEC);
            if (i_cfg_we) begin
                if (i_cfg_idx == urbc_pkg::CFG_WILDCARD_UID) r_wuid <= i_cfg_data;
                else r_learn <= i_cfg_data[0];
            end
            if (s_wild_we) r_wild[r_cls] <= s_wild_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_mode    <= i_mode;
            r_cls     <= i_rule_type;
            r_rule    <= i_rule_index;
            r_user    <= i_user_id;
            r_verdict <= i_verdict_in;
        end
        if (r_state == S_RED2) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_hit_bm   <= n_hit_bm;
            r_any_free <= n_any_free;
            r_free_idx <= n_free_idx;
        end
        if (r_state == S_EXEC) begin
            r_o_status  <= s_status;
            r_o_verdict <= s_vout;
            r_o_free    <= s_free;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_verdict_out = r_o_verdict;
    assign o_free_rule   = r_o_free;

endmodule
